// File: rtl/comment_strip_filter_top_macros.svh
// Assertion macros used by the comment strip filter output queue.
`ifndef COMMENT_STRIP_FILTER_TOP_MACROS_SVH
`define COMMENT_STRIP_FILTER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CSF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define CSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/csf_pkg.sv
package csf_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int COUNT_W    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [1:0] n;
        logic [7:0] b0;
        logic [7:0] b1;
    } result_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } entry_t;

endpackage

// File: rtl/comment_strip_filter_top.sv
// Channel   Handshake               Payload
// input     in_valid / in_ready     in_byte
// output    out_valid / out_ready   out_byte, last
//
// An accepted byte waits in the input register, is decoded there, and its results
// enter the output queue once it has room; out_valid follows the queue's count.
// One byte is taken every cycle while each yields at most one result and the output
// is ready; the output port moves one result per cycle, so two-result bytes queue up.
// Reset clears the scanner to normal mode at line start and empties the queue.
// A stalled output holds the input register once the queue lacks room for two results.
module comment_strip_filter_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              room;
    logic              consume;
    csf_pkg::result_t  result;

    assign consume  = in_valid_reg && room;
    assign in_ready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= in_byte;
        end
    end

    csf_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (consume),
        .in_byte (in_byte_reg),
        .result  (result)
    );

    csf_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (consume),
        .result    (result),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

// File: rtl/csf_step.sv
module csf_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        in_byte,
    output csf_pkg::result_t  result
);

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [2:0] MODE_NORMAL     = 3'd0;
    localparam logic [2:0] MODE_SLASH      = 3'd1;
    localparam logic [2:0] MODE_BLOCK      = 3'd2;
    localparam logic [2:0] MODE_BLOCK_STAR = 3'd3;
    localparam logic [2:0] MODE_AFTER      = 3'd4;
    localparam logic [2:0] MODE_HASH       = 3'd5;
    localparam logic [2:0] MODE_HASH_ESC   = 3'd6;

    logic [2:0] mode_reg;
    logic [2:0] mode_next;
    logic       line_start_reg;
    logic       line_start_next;
    logic       is_eol;

    assign is_eol = (in_byte == CH_NL) || (in_byte == CH_NUL);

    always_comb
    begin
        mode_next       = mode_reg;
        line_start_next = line_start_reg;
        result.n        = 2'd0;
        result.b0       = in_byte;
        result.b1       = in_byte;
        unique case (mode_reg)
            MODE_SLASH:
            begin
                if (in_byte == CH_STAR)
                begin
                    mode_next = MODE_BLOCK;
                end
                else
                begin
                    // The held slash goes out first; a hash after it is never at line start.
                    result.b0 = CH_SLASH;
                    if (in_byte == CH_SLASH)
                    begin
                        mode_next       = MODE_SLASH;
                        line_start_next = 1'b0;
                        result.n        = 2'd1;
                    end
                    else
                    begin
                        mode_next       = MODE_NORMAL;
                        line_start_next = is_eol;
                        result.n        = 2'd2;
                    end
                end
            end
            MODE_BLOCK:
            begin
                if (in_byte == CH_STAR)
                begin
                    mode_next = MODE_BLOCK_STAR;
                end
            end
            MODE_BLOCK_STAR:
            begin
                if (in_byte == CH_SLASH)
                begin
                    mode_next = MODE_AFTER;
                end
                else if (in_byte != CH_STAR)
                begin
                    mode_next = MODE_BLOCK;
                end
            end
            MODE_AFTER:
            begin
                mode_next       = MODE_NORMAL;
                line_start_next = is_eol;
                result.n        = 2'd1;
            end
            MODE_HASH:
            begin
                if (in_byte == CH_BSLASH)
                begin
                    mode_next = MODE_HASH_ESC;
                end
                else if (in_byte == CH_NL)
                begin
                    mode_next       = MODE_NORMAL;
                    line_start_next = 1'b1;
                    result.n        = 2'd1;
                end
            end
            MODE_HASH_ESC:
            begin
                mode_next = MODE_HASH;
            end
            default:
            begin
                if (in_byte == CH_SLASH)
                begin
                    mode_next       = MODE_SLASH;
                    line_start_next = 1'b0;
                end
                else if ((in_byte == CH_HASH) && line_start_reg)
                begin
                    mode_next = MODE_HASH;
                end
                else
                begin
                    mode_next       = MODE_NORMAL;
                    line_start_next = is_eol;
                    result.n        = 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_NORMAL;
            line_start_reg <= 1'b1;
        end
        else if (fire)
        begin
            mode_reg       <= mode_next;
            line_start_reg <= line_start_next;
        end
    end

endmodule

// File: rtl/csf_out_fifo.sv
`include "comment_strip_filter_top_macros.svh"

module csf_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  csf_pkg::result_t  result,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              last
);

    csf_pkg::entry_t                    mem_reg [csf_pkg::FIFO_DEPTH];
    logic [csf_pkg::FIFO_AW-1:0]        wr_ptr_reg;
    logic [csf_pkg::FIFO_AW-1:0]        wr_ptr_next;
    logic [csf_pkg::FIFO_AW-1:0]        rd_ptr_reg;
    logic [csf_pkg::COUNT_W-1:0]        count_reg;
    logic [csf_pkg::COUNT_W-1:0]        count_next;
    logic [csf_pkg::COUNT_W-1:0]        push_n;
    logic                               pop;

    assign push_n    = push ? {{(csf_pkg::COUNT_W-2){1'b0}}, result.n}
                            : {csf_pkg::COUNT_W{1'b0}};
    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != {csf_pkg::COUNT_W{1'b0}});
    assign room      = (count_reg <= csf_pkg::COUNT_W'(csf_pkg::FIFO_DEPTH - 2));
    assign out_byte  = mem_reg[rd_ptr_reg].data;
    assign last      = mem_reg[rd_ptr_reg].last;

    assign wr_ptr_next = wr_ptr_reg + csf_pkg::FIFO_AW'(1);
    assign count_next  = count_reg + push_n - {{(csf_pkg::COUNT_W-1){1'b0}}, pop};

    always_ff @(posedge clk)
    begin
        if (push && (result.n != 2'd0))
        begin
            mem_reg[wr_ptr_reg].data <= result.b0;
            mem_reg[wr_ptr_reg].last <= (result.n == 2'd1);
        end
        if (push && (result.n == 2'd2))
        begin
            mem_reg[wr_ptr_next].data <= result.b1;
            mem_reg[wr_ptr_next].last <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= {csf_pkg::FIFO_AW{1'b0}};
            rd_ptr_reg <= {csf_pkg::FIFO_AW{1'b0}};
            count_reg  <= {csf_pkg::COUNT_W{1'b0}};
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_n[csf_pkg::FIFO_AW-1:0];
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + csf_pkg::FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    `CSF_ASSERT_IMPL(a_no_overflow, clk, rst_n, push,
        (count_reg + push_n) <= csf_pkg::COUNT_W'(csf_pkg::FIFO_DEPTH))
    `CSF_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1,
        count_reg <= csf_pkg::COUNT_W'(csf_pkg::FIFO_DEPTH))
    `CSF_ASSERT_NEXT(a_count_track, clk, rst_n, 1'b1,
        count_reg == ($past(count_reg) + $past(push_n) - {{(csf_pkg::COUNT_W-1){1'b0}}, $past(pop)}))

endmodule

// File: tb/sv/comment_strip_filter_top_test.sv
`timescale 1ns / 100ps

package csf_tb_pkg;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [2:0] {
        SCAN_NORMAL     = 3'd0,
        SCAN_SLASH      = 3'd1,
        SCAN_BLOCK      = 3'd2,
        SCAN_BLOCK_STAR = 3'd3,
        SCAN_AFTER      = 3'd4,
        SCAN_HASH       = 3'd5,
        SCAN_HASH_ESC   = 3'd6
    } scan_mode_e;

    class stripped_text_checker;

        scan_mode_e      mode;
        bit              line_start;
        csf_pkg::entry_t step_q[$];
        csf_pkg::entry_t expected_text_q[$];

        function new();
            mode       = SCAN_NORMAL;
            line_start = 1'b1;
        endfunction

        local function void put_text(input logic [7:0] b);
            csf_pkg::entry_t e;
            e.data = b;
            e.last = 1'b0;
            step_q.push_back(e);
            line_start = (b == CH_NL || b == CH_NUL);
        endfunction

        local function void scan_plain(input logic [7:0] b);
            if (b == CH_SLASH)
            begin
                mode       = SCAN_SLASH;
                line_start = 1'b0;
            end
            else if (b == CH_HASH && line_start)
            begin
                mode = SCAN_HASH;
            end
            else
            begin
                mode = SCAN_NORMAL;
                put_text(b);
            end
        endfunction

        function void note_raw_byte(input logic [7:0] b);
            step_q.delete();
            unique case (mode)
                SCAN_SLASH:
                begin
                    if (b == CH_STAR)
                    begin
                        mode = SCAN_BLOCK;
                    end
                    else
                    begin
                        put_text(CH_SLASH);
                        mode = SCAN_NORMAL;
                        scan_plain(b);
                    end
                end
                SCAN_BLOCK:
                begin
                    if (b == CH_STAR)
                        mode = SCAN_BLOCK_STAR;
                end
                SCAN_BLOCK_STAR:
                begin
                    if (b == CH_SLASH)
                        mode = SCAN_AFTER;
                    else if (b != CH_STAR)
                        mode = SCAN_BLOCK;
                end
                SCAN_AFTER:
                begin
                    mode = SCAN_NORMAL;
                    put_text(b);
                end
                SCAN_HASH:
                begin
                    if (b == CH_BSLASH)
                    begin
                        mode = SCAN_HASH_ESC;
                    end
                    else if (b == CH_NL)
                    begin
                        mode = SCAN_NORMAL;
                        put_text(b);
                    end
                end
                SCAN_HASH_ESC:
                begin
                    mode = SCAN_HASH;
                end
                default:
                begin
                    scan_plain(b);
                end
            endcase
            if (step_q.size() > 0)
                step_q[step_q.size() - 1].last = 1'b1;
            foreach (step_q[i])
                expected_text_q.push_back(step_q[i]);
        endfunction

        // Returns an empty string when the byte matches the oldest expectation.
        function string check_filtered_byte(input logic [7:0] data, input logic last_bit);
            csf_pkg::entry_t want;
            if (expected_text_q.size() == 0)
                return $sformatf("byte %02h last %0b arrived with nothing expected",
                                 data, last_bit);
            want = expected_text_q.pop_front();
            if (data !== want.data || last_bit !== want.last)
                return $sformatf("got byte %02h last %0b, expected byte %02h last %0b",
                                 data, last_bit, want.data, want.last);
            return "";
        endfunction

        function int pending();
            return expected_text_q.size();
        endfunction

    endclass

endpackage

module comment_strip_filter_top_test;

    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 160;
    localparam int RANDOM_ITEMS  = 1200;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       last;

    csf_tb_pkg::stripped_text_checker text_checker;
    logic [7:0]                       raw_text_q[$];
    int                               mismatch_count;
    int                               quiet_cycles;
    int                               in_idle_pct;
    int                               out_idle_pct;
    bit                               hold_request;

    comment_strip_filter_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    task automatic report(input string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function automatic logic [7:0] pick_byte();
        unique case ($urandom_range(0, 9))
            0: return csf_tb_pkg::CH_SLASH;
            1: return csf_tb_pkg::CH_STAR;
            2: return csf_tb_pkg::CH_HASH;
            3: return csf_tb_pkg::CH_BSLASH;
            4: return csf_tb_pkg::CH_NL;
            5: return csf_tb_pkg::CH_NUL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_random_chunk();
        int kind;
        kind = $urandom_range(0, 19);
        if (kind < 7)
        begin
            raw_text_q.push_back(csf_tb_pkg::CH_SLASH);
            raw_text_q.push_back(csf_tb_pkg::CH_STAR);
            repeat ($urandom_range(0, 6))
                raw_text_q.push_back(pick_byte());
            repeat ($urandom_range(1, 3))
                raw_text_q.push_back(csf_tb_pkg::CH_STAR);
            raw_text_q.push_back(csf_tb_pkg::CH_SLASH);
            raw_text_q.push_back(pick_byte());
        end
        else if (kind < 14)
        begin
            raw_text_q.push_back(csf_tb_pkg::CH_NL);
            raw_text_q.push_back(csf_tb_pkg::CH_HASH);
            repeat ($urandom_range(0, 8))
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    raw_text_q.push_back(csf_tb_pkg::CH_BSLASH);
                    raw_text_q.push_back(pick_byte());
                end
                else
                begin
                    raw_text_q.push_back(8'($urandom_range(0, 255)));
                end
            end
            raw_text_q.push_back(csf_tb_pkg::CH_NL);
        end
        else if (kind < 18)
        begin
            repeat ($urandom_range(1, 6))
                raw_text_q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                raw_text_q.push_back(pick_byte());
        end
    endtask

    task automatic send_raw_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Receiver side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        string msg;
        bit    moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (in_valid && in_ready)
            begin
                text_checker.note_raw_byte(in_byte);
                moved = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                msg = text_checker.check_filtered_byte(out_byte, last);
                if (msg != "")
                    report(msg);
                moved = 1'b1;
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] directed[];
        int         directed_count;

        directed = '{
            csf_tb_pkg::CH_HASH, csf_tb_pkg::CH_BSLASH, csf_tb_pkg::CH_NL,
            csf_tb_pkg::CH_SLASH, csf_tb_pkg::CH_NL,
            csf_tb_pkg::CH_SLASH, csf_tb_pkg::CH_STAR, "x", csf_tb_pkg::CH_STAR,
            csf_tb_pkg::CH_STAR, csf_tb_pkg::CH_SLASH, csf_tb_pkg::CH_HASH,
            csf_tb_pkg::CH_SLASH, csf_tb_pkg::CH_STAR, csf_tb_pkg::CH_STAR,
            csf_tb_pkg::CH_SLASH, csf_tb_pkg::CH_SLASH,
            csf_tb_pkg::CH_SLASH, csf_tb_pkg::CH_HASH,
            csf_tb_pkg::CH_NUL, csf_tb_pkg::CH_HASH, 8'hFF, csf_tb_pkg::CH_NL,
            csf_tb_pkg::CH_SLASH, csf_tb_pkg::CH_STAR, csf_tb_pkg::CH_STAR,
            csf_tb_pkg::CH_SLASH, csf_tb_pkg::CH_STAR,
            csf_tb_pkg::CH_SLASH, 8'hFF
        };

        text_checker   = new();
        mismatch_count = 0;
        quiet_cycles   = 0;
        in_idle_pct    = 32;
        out_idle_pct   = 32;
        hold_request   = 1'b0;
        rst_n          = 1'b0;
        in_valid      <= 1'b0;
        in_byte       <= 8'h00;

        foreach (directed[i])
            raw_text_q.push_back(directed[i]);
        directed_count = raw_text_q.size();
        while (raw_text_q.size() < directed_count + RANDOM_ITEMS)
            add_random_chunk();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (raw_text_q[i])
        begin
            if (i == 300)
                hold_request = 1'b1;
            in_idle_pct  = (i >= 500 && i < 750) ? 0 : 32;
            out_idle_pct = (i >= 500 && i < 750) ? 0 : 32;
            send_raw_byte(raw_text_q[i]);
        end
        in_valid     <= 1'b0;
        out_idle_pct  = 32;
        @(posedge clk);

        while (text_checker.pending() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (text_checker.pending() != 0)
            report($sformatf("%0d expected bytes never arrived", text_checker.pending()));

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
